// File: rtl/core/rmdr_pkg.sv
// Shared types and constants for the rescale multiply-divide-round core.
package rmdr_pkg;

  localparam int unsigned Steps = 128;
  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

  localparam logic [2:0] ModeTowardZero = 3'd0;
  localparam logic [2:0] ModeAwayZero = 3'd1;
  localparam logic [2:0] ModeDown = 3'd2;
  localparam logic [2:0] ModeUp = 3'd3;
  localparam logic [2:0] ModeBad = 3'd4;
  localparam logic [2:0] ModeNearest = 3'd5;

  typedef struct packed {
    logic signed [63:0] value_a;
    logic signed [63:0] multiplier_b;
    logic signed [63:0] divisor_c;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] quotient;
    logic               invalid_args;
    logic               overflow;
  } out_beat_t;

  typedef struct packed {
    logic         inv;
    logic         neg;
    logic [62:0]  c;
    logic [62:0]  rem;
    logic [127:0] work;
  } div_t;

endpackage

// File: rtl/core/rmdr_front.sv
// Argument check, bias select, split 64x64 multiply and numerator sum.
module rmdr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  rmdr_pkg::in_beat_t in_beat,
  input  logic [2:0]        mode,
  output logic              div_valid,
  output rmdr_pkg::div_t    div_out
);

  logic [63:0] a, b, c, mag, r;
  logic        neg, inv;
  logic [2:0]  mode2;

  logic         va_r, inv_a_r, neg_a_r;
  logic [62:0]  c_a_r;
  logic [63:0]  r_a_r, p0_r, p1_r, p2_r, p3_r;
  logic         vb_r;
  rmdr_pkg::div_t div_r;
  logic [127:0] num;

  always_comb begin
    a = in_beat.value_a;
    b = in_beat.multiplier_b;
    c = in_beat.divisor_c;
    neg = a[63];
    mag = neg ? (64'd0 - a) : a;
    mode2 = neg ? (mode ^ {2'b00, mode[1]}) : mode;
    inv = (c == 64'd0) || c[63] || b[63] || (mode == rmdr_pkg::ModeBad)
          || (mode > rmdr_pkg::ModeNearest);
    if (mode2 == rmdr_pkg::ModeNearest) begin
      r = c >> 1;
    end else if (mode2[0]) begin
      r = c - 64'd1;
    end else begin
      r = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_a_r <= inv;
      neg_a_r <= neg;
      c_a_r <= c[62:0];
      r_a_r <= r;
      p0_r <= mag[31:0] * b[31:0];
      p1_r <= mag[31:0] * b[63:32];
      p2_r <= mag[63:32] * b[31:0];
      p3_r <= mag[63:32] * b[63:32];
    end
  end

  assign num = {64'd0, p0_r} + {32'd0, p1_r, 32'd0} + {32'd0, p2_r, 32'd0}
             + {p3_r, 64'd0} + {64'd0, r_a_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r.inv <= inv_a_r;
      div_r.neg <= neg_a_r;
      div_r.c <= c_a_r;
      div_r.rem <= 63'd0;
      div_r.work <= num;
    end
  end

  assign div_valid = vb_r;
  assign div_out = div_r;

endmodule

// File: rtl/core/rmdr_cell.sv
// One restoring-division step: shift in a numerator bit, compare, subtract.
module rmdr_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           prev_valid,
  input  rmdr_pkg::div_t prev,
  output logic           next_valid,
  output rmdr_pkg::div_t next
);

  logic [63:0] trial;
  logic        ge;
  rmdr_pkg::div_t stage_nxt, stage_r;
  logic        valid_r;

  always_comb begin
    trial = {prev.rem, prev.work[127]};
    ge = trial >= {1'b0, prev.c};
    stage_nxt = prev;
    stage_nxt.rem = ge ? 63'(trial - {1'b0, prev.c}) : trial[62:0];
    stage_nxt.work = {prev.work[126:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stage_r <= stage_nxt;
    end
  end

  assign next_valid = valid_r;
  assign next = stage_r;

endmodule

// File: rtl/core/rescale_multiply_divide_round_core.sv
// Top level of the rescale multiply-divide-round core.
// Computes round(value_a * multiplier_b / divisor_c) with an exact 128-bit
// product and the mode in the mode_r register (reset: nearest). One
// beat is accepted every cycle unless the pipeline is stalled; a beat passes
// through the registered split multiply and numerator sum, a row of 128
// division cells that each give one quotient bit, and one output register.
// A stall on the output while out_valid is high holds the whole pipeline.
module rescale_multiply_divide_round_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmdr_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output rmdr_pkg::out_beat_t out_beat,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata
);

  logic [2:0] mode_r;
  logic       adv;
  logic       chain_valid [0:rmdr_pkg::Steps];
  rmdr_pkg::div_t chain [0:rmdr_pkg::Steps];
  rmdr_pkg::div_t fin;
  rmdr_pkg::out_beat_t out_nxt, out_r;
  logic       out_valid_r;

  assign adv = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rmdr_pkg::ModeNearest;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  rmdr_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid), .in_beat(in_beat),
    .mode(mode_r), .div_valid(chain_valid[0]), .div_out(chain[0])
  );

  for (genvar i = 0; i < rmdr_pkg::Steps; i++) begin : g_cell
    rmdr_cell u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .prev_valid(chain_valid[i]), .prev(chain[i]),
      .next_valid(chain_valid[i+1]), .next(chain[i+1])
    );
  end

  assign fin = chain[rmdr_pkg::Steps];

  always_comb begin
    if (fin.inv) begin
      out_nxt.quotient = rmdr_pkg::MaxPos;
      out_nxt.invalid_args = 1'b1;
      out_nxt.overflow = 1'b0;
    end else if (fin.neg) begin
      out_nxt.quotient = 64'd0 - fin.work[63:0];
      out_nxt.invalid_args = 1'b0;
      out_nxt.overflow = (|fin.work[127:64]) || (fin.work[63:0] > rmdr_pkg::SignBit);
    end else begin
      out_nxt.quotient = fin.work[63:0];
      out_nxt.invalid_args = 1'b0;
      out_nxt.overflow = (|fin.work[127:64]) || (fin.work[63:0] > rmdr_pkg::MaxPos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain_valid[rmdr_pkg::Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat = out_r;

`ifndef SYNTHESIS
  a_inv_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.invalid_args |-> out_r.quotient == rmdr_pkg::MaxPos && !out_r.overflow)
    else $error("invalid beat without max quotient");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid_r && out_stall))
    else $error("input stall does not follow output hold");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r) && $stable(chain_valid[0]))
    else $error("pipeline moved during stall");
`endif

endmodule
